// ===== rtl/fxd_pkg.sv =====
// Shared types and constants for the fixup record stream decoder.
package fxd_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TRUNC      = 3'd1,
    ST_LIST       = 3'd2,
    ST_SRC_TYPE   = 3'd3,
    ST_BAD_OBJECT = 3'd4
  } status_t;

  typedef enum logic {
    OP_TABLE_WRITE = 1'b0,
    OP_RESULT      = 1'b1
  } op_t;

  typedef enum logic {
    REG_PAGE_BYTES    = 1'b0,
    REG_VALID_OBJECTS = 1'b1
  } reg_idx_t;

  localparam logic [7:0]  SRC_LIST_BIT    = 8'h20;
  localparam logic [7:0]  SRC_TYPE_MASK   = 8'h0f;
  localparam logic [7:0]  SRC_TYPE_OFF32  = 8'h07;
  localparam logic [7:0]  TGT_EXT_MASK    = 8'h03;
  localparam logic [7:0]  TGT_WIDE_ORD    = 8'h40;
  localparam logic [7:0]  TGT_OFF32       = 8'h10;

  localparam logic [16:0] PAGE_BYTES_RESET    = 17'd4096;
  localparam logic [4:0]  VALID_OBJECTS_RESET = 5'd0;

  localparam int CMD_QUEUE_DEPTH = 4;

  // One command from the parser to the execution side.
  typedef struct packed {
    op_t         op;
    status_t     status;
    logic        warn_ext;
    logic        warn_wide;
    logic [7:0]  slot;        // table slot to write, or object index to read
    logic [31:0] value;       // base address to write, or target offset
    logic [15:0] page;
    logic [15:0] src_offset;
  } cmd_t;

endpackage

// ===== rtl/fxd_front.sv =====
// Record byte parser: tracks the record position and issues commands.
module fxd_front #(
  parameter int MAX_OBJECTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              func,
  input  logic [7:0]        data_byte,
  input  logic              last_in_page,
  input  logic [15:0]       page_in_object,
  input  logic [3:0]        object_slot,
  input  logic [31:0]       base_value,
  input  logic [4:0]        valid_objects,
  output logic              push,
  output fxd_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    P_SRC_FLAGS, P_TGT_FLAGS, P_SRC_LO, P_SRC_HI, P_OBJECT,
    P_TGT_0, P_TGT_1, P_TGT_2, P_TGT_3
  } pos_t;

  pos_t        pos, pos_next;
  logic [7:0]  source_flags, source_flags_next;
  logic [7:0]  target_flags, target_flags_next;
  logic [15:0] source_offset, source_offset_next;
  logic [7:0]  object_number, object_number_next;
  logic [23:0] target_offset, target_offset_next;
  logic        error_latched, error_latched_next;

  logic              do_fail, do_finish, fail_warn;
  fxd_pkg::status_t  fail_status;
  logic [31:0]       tgt_final;
  logic [7:0]        cur_tf;
  logic [8:0]        limit;
  logic              wide;

  assign limit = ({4'b0, valid_objects} < 9'(MAX_OBJECTS)) ? {4'b0, valid_objects}
                                                            : 9'(MAX_OBJECTS);
  assign wide   = (target_flags & fxd_pkg::TGT_OFF32) != 8'h00;
  // Warnings use the target flags as they stand after this byte.
  assign cur_tf = (pos == P_TGT_FLAGS) ? data_byte : target_flags;

  always_comb begin
    pos_next           = pos;
    source_flags_next  = source_flags;
    target_flags_next  = target_flags;
    source_offset_next = source_offset;
    object_number_next = object_number;
    target_offset_next = target_offset;
    error_latched_next = error_latched;
    do_fail            = 1'b0;
    do_finish          = 1'b0;
    fail_warn          = 1'b0;
    fail_status        = fxd_pkg::ST_OK;
    tgt_final          = '0;
    if (accept && func && !error_latched) begin
      unique case (pos)
        P_SRC_FLAGS: begin
          source_flags_next = data_byte;
          pos_next = P_TGT_FLAGS;
          if (last_in_page) begin
            do_fail = 1'b1;
            fail_status = fxd_pkg::ST_TRUNC;
          end
        end
        P_TGT_FLAGS: begin
          target_flags_next = data_byte;
          pos_next = P_SRC_LO;
          priority if ((source_flags & fxd_pkg::SRC_LIST_BIT) != 8'h00) begin
            do_fail = 1'b1;
            fail_status = fxd_pkg::ST_LIST;
          end else if ((source_flags & fxd_pkg::SRC_TYPE_MASK) != fxd_pkg::SRC_TYPE_OFF32) begin
            do_fail = 1'b1;
            fail_status = fxd_pkg::ST_SRC_TYPE;
          end else if (last_in_page) begin
            do_fail = 1'b1;
            fail_warn = 1'b1;
            fail_status = fxd_pkg::ST_TRUNC;
          end else begin
            // flags are fine; advance to the source offset
          end
        end
        P_SRC_LO: begin
          source_offset_next = {8'h00, data_byte};
          pos_next = P_SRC_HI;
        end
        P_SRC_HI: begin
          source_offset_next = {data_byte, source_offset[7:0]};
          pos_next = P_OBJECT;
        end
        P_OBJECT: begin
          object_number_next = data_byte;
          pos_next = P_TGT_0;
          if (data_byte == 8'h00 || {1'b0, data_byte} > limit) begin
            do_fail = 1'b1;
            fail_warn = 1'b1;
            fail_status = fxd_pkg::ST_BAD_OBJECT;
          end
        end
        P_TGT_0: begin
          target_offset_next = {16'h0000, data_byte};
          pos_next = P_TGT_1;
        end
        P_TGT_1: begin
          target_offset_next = {8'h00, data_byte, target_offset[7:0]};
          if (!wide) begin
            do_finish = 1'b1;
            tgt_final = {16'h0000, data_byte, target_offset[7:0]};
          end else begin
            pos_next = P_TGT_2;
          end
        end
        P_TGT_2: begin
          target_offset_next = {data_byte, target_offset[15:0]};
          pos_next = P_TGT_3;
        end
        P_TGT_3: begin
          do_finish = 1'b1;
          tgt_final = {data_byte, target_offset[23:0]};
        end
        default: pos_next = P_SRC_FLAGS;
      endcase
      // Truncation on middle bytes, lowest priority
      if (!do_fail && !do_finish && last_in_page &&
          pos != P_SRC_FLAGS && pos != P_TGT_FLAGS) begin
        do_fail = 1'b1;
        fail_warn = 1'b1;
        fail_status = fxd_pkg::ST_TRUNC;
      end
      if (do_fail) begin
        error_latched_next = 1'b1;
        pos_next = P_SRC_FLAGS;
      end
      if (do_finish) pos_next = P_SRC_FLAGS;
    end
  end

  always_comb begin
    push = accept && (!func || do_fail || do_finish);
    cmd  = '0;
    if (!func) begin
      cmd.op    = fxd_pkg::OP_TABLE_WRITE;
      cmd.slot  = {4'b0000, object_slot};
      cmd.value = base_value;
    end else begin
      cmd.op         = fxd_pkg::OP_RESULT;
      cmd.status     = do_fail ? fail_status : fxd_pkg::ST_OK;
      cmd.warn_ext   = (do_finish || fail_warn) && ((cur_tf & fxd_pkg::TGT_EXT_MASK) != 8'h00);
      cmd.warn_wide  = (do_finish || fail_warn) && ((cur_tf & fxd_pkg::TGT_WIDE_ORD) != 8'h00);
      cmd.slot       = object_number - 8'd1;
      cmd.value      = tgt_final;
      cmd.page       = page_in_object;
      cmd.src_offset = source_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= P_SRC_FLAGS;
      source_flags  <= '0;
      target_flags  <= '0;
      source_offset <= '0;
      object_number <= '0;
      target_offset <= '0;
      error_latched <= 1'b0;
    end else begin
      pos           <= pos_next;
      source_flags  <= source_flags_next;
      target_flags  <= target_flags_next;
      source_offset <= source_offset_next;
      object_number <= object_number_next;
      target_offset <= target_offset_next;
      error_latched <= error_latched_next;
    end
  end

endmodule

// ===== rtl/fxd_queue.sv =====
// Small command queue between the parser and the execution side.
module fxd_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fxd_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output fxd_pkg::cmd_t  head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fxd_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/fxd_back.sv =====
// Execution side: base table, offset multiply, address add, result register.
module fxd_back #(
  parameter int MAX_OBJECTS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  fxd_pkg::cmd_t  q_cmd,
  output logic           q_pop,
  input  logic [16:0]    page_bytes,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [31:0]    fixup_offset,
  output logic [31:0]    fixup_address,
  output logic [2:0]     status,
  output logic           warn_external,
  output logic           warn_wide_ordinal
);

  localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

  logic [31:0] base_table [MAX_OBJECTS];

  logic              s1_valid;
  fxd_pkg::status_t  s1_status;
  logic              s1_warn_ext, s1_warn_wide;
  logic [31:0]       s1_prod, s1_base, s1_tgt;
  logic [15:0]       s1_src;

  fxd_pkg::status_t  out_status;
  logic [32:0]       prod_full;
  logic              adv_out, s1_free, is_write, load_s1, slot_ok;
  logic [31:0]       off_sum, addr_sum;

  assign is_write  = q_cmd.op == fxd_pkg::OP_TABLE_WRITE;
  assign adv_out   = s1_valid && (!out_valid || out_ready);
  assign s1_free   = !s1_valid || adv_out;
  // Table writes retire straight from the queue; results need stage 1 free.
  assign q_pop     = q_valid && (is_write || s1_free);
  assign load_s1   = q_pop && !is_write;
  assign slot_ok   = {1'b0, q_cmd.slot} < 9'(MAX_OBJECTS);
  assign prod_full = q_cmd.page * page_bytes;
  assign off_sum   = s1_prod + {{16{s1_src[15]}}, s1_src};
  assign addr_sum  = s1_base + s1_tgt;

  always_ff @(posedge clk) begin
    if (q_pop && is_write && slot_ok) base_table[q_cmd.slot[IDX_W-1:0]] <= q_cmd.value;
    if (load_s1) s1_base <= base_table[q_cmd.slot[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load_s1) begin
      s1_status    <= q_cmd.status;
      s1_warn_ext  <= q_cmd.warn_ext;
      s1_warn_wide <= q_cmd.warn_wide;
      s1_prod      <= prod_full[31:0];
      s1_tgt       <= q_cmd.value;
      s1_src       <= q_cmd.src_offset;
    end
    if (adv_out) begin
      out_status        <= s1_status;
      warn_external     <= s1_warn_ext;
      warn_wide_ordinal <= s1_warn_wide;
      fixup_offset      <= (s1_status == fxd_pkg::ST_OK) ? off_sum : 32'h0;
      fixup_address     <= (s1_status == fxd_pkg::ST_OK) ? addr_sum : 32'h0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_s1)      s1_valid <= 1'b1;
      else if (adv_out) s1_valid <= 1'b0;
      if (adv_out)        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign status = out_status;

endmodule

// ===== rtl/fixup_record_stream_decoder_top.sv =====
// Top level of the fixup record stream decoder.
// Takes one request per cycle, either a base table load (func 0) or one byte
// of the fixup record stream (func 1), and returns one result per completed
// record or per first error. The parser decodes every byte in the cycle it is
// accepted and hands table loads, finished records and errors to a four-entry
// command queue; the execution side reads the base table and multiplies page
// index by page size in one stage, then adds into the output register.
// Requests stall only when the command queue is full, which happens only
// while the result side is held off. Errors are sticky: after the first one,
// record bytes are dropped until reset while table loads still take effect.
// Configuration lives on an APB-style port: the page size in bytes at byte
// address 0, the number of valid objects at 4; write them only while no
// request is in flight.
module fixup_record_stream_decoder_top #(
  parameter int MAX_OBJECTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  data_byte,
  input  logic        last_in_page,
  input  logic [15:0] page_in_object,
  input  logic [3:0]  object_slot,
  input  logic [31:0] base_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] fixup_offset,
  output logic [31:0] fixup_address,
  output logic [2:0]  status,
  output logic        warn_external,
  output logic        warn_wide_ordinal
);

  logic [16:0]        page_bytes;
  logic [4:0]         valid_objects;
  fxd_pkg::reg_idx_t  reg_sel;
  logic               cfg_write;

  logic               accept, push, q_full, q_valid, q_pop;
  fxd_pkg::cmd_t      push_cmd, head_cmd;

  // Register select ignores the byte lane bits.
  assign reg_sel   = fxd_pkg::reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    unique case (reg_sel)
      fxd_pkg::REG_PAGE_BYTES:    prdata = {15'h0000, page_bytes};
      fxd_pkg::REG_VALID_OBJECTS: prdata = {27'h0000000, valid_objects};
      default:                    prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes    <= fxd_pkg::PAGE_BYTES_RESET;
      valid_objects <= fxd_pkg::VALID_OBJECTS_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        fxd_pkg::REG_PAGE_BYTES:    page_bytes    <= pwdata[16:0];
        fxd_pkg::REG_VALID_OBJECTS: valid_objects <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Hold off new requests only when the command queue has no room.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  fxd_front #(.MAX_OBJECTS(MAX_OBJECTS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .func           (func),
    .data_byte      (data_byte),
    .last_in_page   (last_in_page),
    .page_in_object (page_in_object),
    .object_slot    (object_slot),
    .base_value     (base_value),
    .valid_objects  (valid_objects),
    .push           (push),
    .cmd            (push_cmd)
  );

  fxd_queue #(.DEPTH(fxd_pkg::CMD_QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  fxd_back #(.MAX_OBJECTS(MAX_OBJECTS)) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_cmd             (head_cmd),
    .q_pop             (q_pop),
    .page_bytes        (page_bytes),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .fixup_offset      (fixup_offset),
    .fixup_address     (fixup_address),
    .status            (status),
    .warn_external     (warn_external),
    .warn_wide_ordinal (warn_wide_ordinal)
  );

endmodule

// ===== rtl/fxd_checker.sv =====
// Port-level checks for the fixup record stream decoder, bound to the top.
module fxd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] fixup_offset,
  input logic [31:0] fixup_address,
  input logic [2:0]  status,
  input logic        warn_external,
  input logic        warn_wide_ordinal
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != fxd_pkg::ST_OK |-> fixup_offset == 32'h0 && fixup_address == 32'h0)
    else $error("error result carries nonzero offset or address");

  a_flag_err_no_warn: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == fxd_pkg::ST_LIST || status == fxd_pkg::ST_SRC_TYPE)
    |-> !warn_external && !warn_wide_ordinal)
    else $error("warning set on flag error");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= fxd_pkg::ST_BAD_OBJECT)
    else $error("status code out of range");

endmodule

bind fixup_record_stream_decoder_top fxd_checker u_fxd_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .fixup_offset      (fixup_offset),
  .fixup_address     (fixup_address),
  .status            (status),
  .warn_external     (warn_external),
  .warn_wide_ordinal (warn_wide_ordinal)
);
